FILE: sv/ldd_pkg.sv
`timescale 1ns / 1ps

package ldd_pkg;

    localparam int LAYERS_DEF  = 10;
    localparam int NODES_DEF   = 4096;
    localparam int EDGES_DEF   = 16384;

    localparam int KIND_W      = 2;
    localparam int LAYER_IDX_W = 4;
    localparam int ENTRY_W     = 14;
    localparam int OFFSET_W    = 14;
    localparam int LENGTH_W    = 15;
    localparam int SYM_W       = 6;
    localparam int TARGET_W    = 12;
    localparam int POS_W       = 60;
    localparam int STATUS_W    = 3;
    // offset plus length always fits here
    localparam int SEARCH_W    = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUERY = 2'd0,
        KIND_NODE  = 2'd1,
        KIND_EDGE  = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_REJECT  = 3'd0,
        ST_ACCEPT  = 3'd1,
        ST_LOADED  = 3'd2,
        ST_REFUSED = 3'd3,
        ST_FAULT   = 3'd4
    } status_t;

    typedef struct packed {
        logic                loaded;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } node_word_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [SYM_W-1:0]    symbol;
    } edge_word_t;

    typedef struct packed {
        logic clear_step;
        logic start_query;
        logic load_node;
        logic load_edge;
        logic node_rd;
        logic open_span;
        logic edge_rd;
        logic narrow;
        logic next_layer;
    } ldd_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic node_oob;
        logic node_loaded;
        logic search_open;
        logic span_end;
        logic sym_hit;
        logic last_layer;
        logic node_load_ok;
        logic edge_load_ok;
    } ldd_stat_t;

endpackage

FILE: sv/ldd_if.sv
`timescale 1ns / 1ps

interface ldd_item_if;
    import ldd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [LAYER_IDX_W-1:0] layer_index;
    logic [ENTRY_W-1:0]     entry_index;
    logic [OFFSET_W-1:0]    span_offset;
    logic [LENGTH_W-1:0]    span_length;
    logic [SYM_W-1:0]       edge_symbol;
    logic [TARGET_W-1:0]    edge_target;
    logic [POS_W-1:0]       position;

    modport source (
        output valid, kind, layer_index, entry_index, span_offset, span_length,
               edge_symbol, edge_target, position,
        input  ready
    );
    modport sink (
        input  valid, kind, layer_index, entry_index, span_offset, span_length,
               edge_symbol, edge_target, position,
        output ready
    );
endinterface

interface ldd_result_if;
    import ldd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;

    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface

interface ldd_cfg_if;
    import ldd_pkg::*;

    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: sv/ldd_dpath.sv
`timescale 1ns / 1ps

module ldd_dpath #(
    parameter int LAYERS          = ldd_pkg::LAYERS_DEF,
    parameter int NODES_PER_LAYER = ldd_pkg::NODES_DEF,
    parameter int EDGES_PER_LAYER = ldd_pkg::EDGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [ldd_pkg::TARGET_W-1:0]    cfg_data,
    input  logic [ldd_pkg::LAYER_IDX_W-1:0] layer_index,
    input  logic [ldd_pkg::ENTRY_W-1:0]     entry_index,
    input  logic [ldd_pkg::OFFSET_W-1:0]    span_offset,
    input  logic [ldd_pkg::LENGTH_W-1:0]    span_length,
    input  logic [ldd_pkg::SYM_W-1:0]       edge_symbol,
    input  logic [ldd_pkg::TARGET_W-1:0]    edge_target,
    input  logic [ldd_pkg::POS_W-1:0]       position,
    input  ldd_pkg::ldd_cmd_t               cmd,
    output ldd_pkg::ldd_stat_t              st
);
    import ldd_pkg::*;

    localparam int NW         = $clog2(NODES_PER_LAYER);
    localparam int EW         = $clog2(EDGES_PER_LAYER);
    localparam int LCW        = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int NODE_DEPTH = LAYERS * (2 ** NW);
    localparam int EDGE_DEPTH = LAYERS * (2 ** EW);
    localparam int NAW        = $clog2(NODE_DEPTH);
    localparam int EAW        = $clog2(EDGE_DEPTH);

    node_word_t node_mem [NODE_DEPTH];
    edge_word_t edge_mem [EDGE_DEPTH];

    node_word_t           node_rd_reg;
    edge_word_t           edge_rd_reg;
    logic [NAW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [TARGET_W-1:0]  root_reg, root_next;
    logic [TARGET_W-1:0]  node_reg, node_next;
    logic [LCW-1:0]       layer_reg, layer_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [SEARCH_W-1:0]  lo_reg, lo_next;
    logic [SEARCH_W-1:0]  hi_reg, hi_next;
    logic [SEARCH_W-1:0]  end_reg, end_next;

    logic [SEARCH_W-1:0]  load_end;
    logic [SEARCH_W-1:0]  rd_end;
    logic [SEARCH_W-1:0]  mid;
    logic [SEARCH_W-1:0]  probe;
    logic [SYM_W-1:0]     sym;
    logic                 layer_ok;
    logic                 node_load_ok;
    logic                 edge_load_ok;
    logic                 node_we;
    logic [NAW-1:0]       node_waddr;
    node_word_t           node_wdata;
    logic [NAW-1:0]       node_raddr;
    logic                 edge_we;
    logic [EAW-1:0]       edge_waddr;
    edge_word_t           edge_wdata;
    logic [EAW-1:0]       edge_raddr;

    always_comb
    begin
        load_end     = SEARCH_W'(span_offset) + SEARCH_W'(span_length);
        layer_ok     = 32'(layer_index) < LAYERS;
        node_load_ok = layer_ok && (32'(entry_index) < NODES_PER_LAYER)
                       && (32'(load_end) <= EDGES_PER_LAYER);
        edge_load_ok = layer_ok && (32'(entry_index) < EDGES_PER_LAYER);

        // clearing pass shares the write port with node loads
        node_we    = cmd.clear_step || (cmd.load_node && node_load_ok);
        node_waddr = cmd.clear_step ? clr_cnt_reg
                   : ((NAW'(LCW'(layer_index)) << NW) | NAW'(NW'(entry_index)));
        node_wdata = cmd.clear_step ? '0 : {1'b1, span_offset, span_length};
        node_raddr = (NAW'(layer_reg) << NW) | NAW'(NW'(node_reg));

        edge_we    = cmd.load_edge && edge_load_ok;
        edge_waddr = (EAW'(LCW'(layer_index)) << EW) | EAW'(EW'(entry_index));
        edge_wdata = {edge_target, edge_symbol};

        rd_end = SEARCH_W'(node_rd_reg.offset) + SEARCH_W'(node_rd_reg.length);
        mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
        // once the interval is empty, the probe lands on the candidate edge
        probe  = (lo_reg < hi_reg) ? mid : lo_reg;
        edge_raddr = (EAW'(layer_reg) << EW) | EAW'(EW'(probe));
        sym    = pos_reg[SYM_W-1:0];
    end

    always_comb
    begin
        clr_cnt_next = cmd.clear_step ? clr_cnt_reg + NAW'(1) : clr_cnt_reg;
        root_next    = cfg_valid ? cfg_data : root_reg;
        node_next    = node_reg;
        layer_next   = layer_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        end_next     = end_reg;
        if (cmd.start_query)
        begin
            node_next  = root_reg;
            layer_next = '0;
            pos_next   = position;
        end
        if (cmd.next_layer)
        begin
            node_next  = edge_rd_reg.target;
            layer_next = layer_reg + LCW'(1);
            // symbols past the position word read as zero
            pos_next   = pos_reg >> SYM_W;
        end
        if (cmd.open_span)
        begin
            lo_next  = SEARCH_W'(node_rd_reg.offset);
            hi_next  = rd_end;
            end_next = rd_end;
        end
        if (cmd.narrow)
        begin
            if (edge_rd_reg.symbol < sym)
            begin
                lo_next = mid + SEARCH_W'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            root_reg    <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            root_reg    <= root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        layer_reg <= layer_next;
        pos_reg   <= pos_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        end_reg   <= end_next;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (cmd.node_rd)
        begin
            node_rd_reg <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        if (cmd.edge_rd)
        begin
            edge_rd_reg <= edge_mem[edge_raddr];
        end
    end

    always_comb
    begin
        st.clear_last   = clr_cnt_reg == NAW'(NODE_DEPTH - 1);
        st.node_oob     = 32'(node_reg) >= NODES_PER_LAYER;
        st.node_loaded  = node_rd_reg.loaded;
        st.search_open  = lo_reg < hi_reg;
        st.span_end     = lo_reg == end_reg;
        st.sym_hit      = edge_rd_reg.symbol == sym;
        st.last_layer   = layer_reg == LCW'(LAYERS - 1);
        st.node_load_ok = node_load_ok;
        st.edge_load_ok = edge_load_ok;
    end

`ifndef SYNTH
    a_probe_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.edge_rd |-> (lo_reg <= hi_reg) && (hi_reg <= end_reg))
        else $error("edge probe outside the node span");

    a_narrow_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.narrow |-> lo_reg < hi_reg)
        else $error("search narrowed on an empty interval");

    a_clear_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear_step && !st.clear_last) |=> clr_cnt_reg == $past(clr_cnt_reg) + NAW'(1))
        else $error("clearing pass skipped an entry");
`endif

endmodule

FILE: sv/ldd_ctrl.sv
`timescale 1ns / 1ps

module ldd_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic [ldd_pkg::KIND_W-1:0]   item_kind,
    output logic                         item_ready,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [ldd_pkg::STATUS_W-1:0] result_status,
    output ldd_pkg::ldd_cmd_t            cmd,
    input  ldd_pkg::ldd_stat_t           st
);
    import ldd_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_NODE_RD,
        S_NODE_CHK,
        S_PROBE,
        S_CMP,
        S_EDGE_CHK,
        S_DELIVER
    } state_t;

    state_t  state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    status_t pend_reg, pend_next;
    logic    out_free;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_status_next = out_status_reg;
        pend_next       = pend_reg;
        out_free        = !out_valid_reg || result_ready;
        item_ready      = state_reg == S_IDLE;
        cmd             = '0;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_DELIVER;
                    case (kind_t'(item_kind))
                        KIND_QUERY:
                        begin
                            cmd.start_query = 1'b1;
                            state_next      = S_NODE_RD;
                        end
                        KIND_NODE:
                        begin
                            cmd.load_node = 1'b1;
                            pend_next     = st.node_load_ok ? ST_LOADED : ST_REFUSED;
                        end
                        KIND_EDGE:
                        begin
                            cmd.load_edge = 1'b1;
                            pend_next     = st.edge_load_ok ? ST_LOADED : ST_REFUSED;
                        end
                        default:
                        begin
                            pend_next = ST_REFUSED;
                        end
                    endcase
                end
            end
            S_NODE_RD:
            begin
                if (st.node_oob)
                begin
                    pend_next  = ST_FAULT;
                    state_next = S_DELIVER;
                end
                else
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = S_NODE_CHK;
                end
            end
            S_NODE_CHK:
            begin
                if (!st.node_loaded)
                begin
                    pend_next  = ST_FAULT;
                    state_next = S_DELIVER;
                end
                else
                begin
                    cmd.open_span = 1'b1;
                    state_next    = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (st.search_open)
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = S_CMP;
                end
                else if (st.span_end)
                begin
                    pend_next  = ST_REJECT;
                    state_next = S_DELIVER;
                end
                else
                begin
                    // fetch the lower bound edge for the final compare
                    cmd.edge_rd = 1'b1;
                    state_next  = S_EDGE_CHK;
                end
            end
            S_CMP:
            begin
                cmd.narrow = 1'b1;
                state_next = S_PROBE;
            end
            S_EDGE_CHK:
            begin
                if (!st.sym_hit)
                begin
                    pend_next  = ST_REJECT;
                    state_next = S_DELIVER;
                end
                else if (st.last_layer)
                begin
                    pend_next  = ST_ACCEPT;
                    state_next = S_DELIVER;
                end
                else
                begin
                    cmd.next_layer = 1'b1;
                    state_next     = S_NODE_RD;
                end
            end
            S_DELIVER:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_REJECT;
            pend_reg       <= ST_REJECT;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            pend_reg       <= pend_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign result_status = out_status_reg;

`ifndef SYNTH
    a_clear_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !out_valid_reg)
        else $error("result word present during clearing pass");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> state_reg != S_IDLE)
        else $error("accepted word did not start work");

    a_deliver_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DELIVER && out_free) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("pending status not moved to output register");
`endif

endmodule

FILE: sv/layered_decision_diagram_lookup.sv
`timescale 1ns / 1ps

// channel  role  handshake      payload
// item     sink  valid / ready  kind, layer_index, entry_index, span_offset, span_length,
//                               edge_symbol, edge_target, position
// result   src   valid / ready  status
// cfg      sink  valid / ready  data (root_node)
//
// after reset a clearing pass walks all LAYERS * 2**clog2(NODES_PER_LAYER) entries of the
// node table (40960 at defaults); no item is taken meanwhile, cfg writes are still taken
// a load word is written as it is taken; a query walks the layers, each with a binary
// search of up to clog2(span length + 1) probes, the probes taken one at a time
// through the one read port of the edge memory
// a query stops early at the first reject or fault
// the output register holds one result; the next word is taken while it waits

module layered_decision_diagram_lookup #(
    parameter int LAYERS          = ldd_pkg::LAYERS_DEF,
    parameter int NODES_PER_LAYER = ldd_pkg::NODES_DEF,
    parameter int EDGES_PER_LAYER = ldd_pkg::EDGES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    ldd_cfg_if.sink      cfg,
    ldd_item_if.sink     item,
    ldd_result_if.source result
);
    import ldd_pkg::*;

    ldd_cmd_t  cmd;
    ldd_stat_t st;

    assign cfg.ready = 1'b1;

    ldd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item.valid),
        .item_kind     (item.kind),
        .item_ready    (item.ready),
        .result_valid  (result.valid),
        .result_ready  (result.ready),
        .result_status (result.status),
        .cmd           (cmd),
        .st            (st)
    );

    ldd_dpath #(
        .LAYERS          (LAYERS),
        .NODES_PER_LAYER (NODES_PER_LAYER),
        .EDGES_PER_LAYER (EDGES_PER_LAYER)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.data),
        .layer_index (item.layer_index),
        .entry_index (item.entry_index),
        .span_offset (item.span_offset),
        .span_length (item.span_length),
        .edge_symbol (item.edge_symbol),
        .edge_target (item.edge_target),
        .position    (item.position),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

FILE: tb/layered_decision_diagram_lookup_test.sv
`timescale 1ns / 1ps

module layered_decision_diagram_lookup_test;
    import ldd_pkg::*;

    localparam int LAYERS = LAYERS_DEF;
    localparam int NODES  = NODES_DEF;
    localparam int EDGES  = EDGES_DEF;

    typedef struct packed {
        kind_t                  kind;
        logic [LAYER_IDX_W-1:0] layer;
        logic [ENTRY_W-1:0]     entry;
        logic [OFFSET_W-1:0]    off;
        logic [LENGTH_W-1:0]    len;
        logic [SYM_W-1:0]       sym;
        logic [TARGET_W-1:0]    tgt;
        logic [POS_W-1:0]       pos;
    } diagram_word_t;

    typedef struct packed {
        diagram_word_t w;
        logic          typed;
        status_t       want;
    } directed_row_t;

    // rows with typed = 0 are checked against the diagram walk
    localparam directed_row_t DIRECTED_ROWS [26] = '{
        '{'{KIND_QUERY, 4'd0, 14'd0, 14'd0, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b1, ST_FAULT},
        '{'{KIND_QUERY, 4'd15, 14'd16383, 14'd16383, 15'd32767, 6'd63, 12'd4095,
            60'hFFFFFFFFFFFFFFF}, 1'b1, ST_FAULT},
        '{'{KIND_BAD, 4'd3, 14'd77, 14'd5, 15'd9, 6'd21, 12'd300, 60'h123456789ABCDEF},
            1'b1, ST_REFUSED},
        '{'{KIND_NODE, 4'd10, 14'd0, 14'd0, 15'd1, 6'd0, 12'd0, 60'd0}, 1'b1, ST_REFUSED},
        '{'{KIND_NODE, 4'd15, 14'd4095, 14'd0, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b1, ST_REFUSED},
        '{'{KIND_NODE, 4'd0, 14'd4096, 14'd0, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b1, ST_REFUSED},
        '{'{KIND_NODE, 4'd0, 14'd16383, 14'd0, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b1, ST_REFUSED},
        '{'{KIND_NODE, 4'd0, 14'd0, 14'd16383, 15'd2, 6'd0, 12'd0, 60'd0}, 1'b1, ST_REFUSED},
        // full-table span, replaced below before any walk can reach it
        '{'{KIND_NODE, 4'd9, 14'd4095, 14'd0, 15'd16384, 6'd0, 12'd0, 60'd0}, 1'b1, ST_LOADED},
        '{'{KIND_NODE, 4'd9, 14'd4095, 14'd1, 15'd16384, 6'd0, 12'd0, 60'd0}, 1'b1, ST_REFUSED},
        '{'{KIND_NODE, 4'd9, 14'd4095, 14'd16383, 15'd32767, 6'd0, 12'd0, 60'd0},
            1'b1, ST_REFUSED},
        '{'{KIND_NODE, 4'd9, 14'd4095, 14'd16383, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b1, ST_LOADED},
        '{'{KIND_EDGE, 4'd10, 14'd0, 14'd0, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b1, ST_REFUSED},
        '{'{KIND_EDGE, 4'd15, 14'd16383, 14'd0, 15'd0, 6'd63, 12'd4095, 60'd0},
            1'b1, ST_REFUSED},
        '{'{KIND_EDGE, 4'd0, 14'd0, 14'd0, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b1, ST_LOADED},
        '{'{KIND_EDGE, 4'd0, 14'd1, 14'd0, 15'd0, 6'd63, 12'd4095, 60'd0}, 1'b1, ST_LOADED},
        '{'{KIND_EDGE, 4'd0, 14'd16383, 14'd0, 15'd0, 6'd63, 12'd4095, 60'd0},
            1'b1, ST_LOADED},
        '{'{KIND_NODE, 4'd0, 14'd0, 14'd0, 15'd2, 6'd0, 12'd0, 60'd0}, 1'b1, ST_LOADED},
        '{'{KIND_QUERY, 4'd0, 14'd0, 14'd0, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b0, ST_REJECT},
        '{'{KIND_QUERY, 4'd0, 14'd0, 14'd0, 15'd0, 6'd0, 12'd0, 60'h3F}, 1'b0, ST_REJECT},
        '{'{KIND_QUERY, 4'd0, 14'd0, 14'd0, 15'd0, 6'd0, 12'd0, 60'h5}, 1'b0, ST_REJECT},
        '{'{KIND_EDGE, 4'd1, 14'd16383, 14'd0, 15'd0, 6'd63, 12'd0, 60'd0}, 1'b1, ST_LOADED},
        '{'{KIND_NODE, 4'd1, 14'd4095, 14'd16383, 15'd1, 6'd0, 12'd0, 60'd0},
            1'b1, ST_LOADED},
        '{'{KIND_QUERY, 4'd0, 14'd0, 14'd0, 15'd0, 6'd0, 12'd0, 60'hFFF}, 1'b0, ST_REJECT},
        // empty span
        '{'{KIND_NODE, 4'd0, 14'd0, 14'd16383, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b1, ST_LOADED},
        '{'{KIND_QUERY, 4'd0, 14'd0, 14'd0, 15'd0, 6'd0, 12'd0, 60'd0}, 1'b1, ST_REJECT}
    };

    logic clk;
    logic rst_n;

    ldd_cfg_if    cfg_ch ();
    ldd_item_if   item_ch ();
    ldd_result_if result_ch ();

    layered_decision_diagram_lookup u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    // own copy of the diagram tables
    logic [OFFSET_W-1:0] span_start [LAYERS][NODES];
    logic [LENGTH_W-1:0] span_size [LAYERS][NODES];
    bit                  node_present [LAYERS][NODES];
    logic [SYM_W-1:0]    edge_symbol_mem [LAYERS][EDGES];
    logic [TARGET_W-1:0] edge_next [LAYERS][EDGES];
    bit                  edge_known [LAYERS][EDGES];
    logic [TARGET_W-1:0] root_copy;

    int unsigned build_base [LAYERS];
    status_t     status_due [$];
    int          error_count;
    int          words_sent;
    int          burst_left;
    int          ready_hold;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic status_t walk_diagram(logic [POS_W-1:0] pos);
        int unsigned node;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned span_end;
        logic [SYM_W-1:0] sym;
        node = root_copy;
        for (int d = 0; d < LAYERS; d++)
        begin
            if (node >= NODES || !node_present[d][node])
                return ST_FAULT;
            sym = pos[SYM_W*d +: SYM_W];
            lo = span_start[d][node];
            span_end = lo + span_size[d][node];
            hi = span_end;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (edge_symbol_mem[d][mid] < sym)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo == span_end || edge_symbol_mem[d][lo] != sym)
                return ST_REJECT;
            node = edge_next[d][lo];
        end
        return ST_ACCEPT;
    endfunction

    function automatic status_t apply_word(diagram_word_t w);
        case (w.kind)
            KIND_QUERY:
                return walk_diagram(w.pos);
            KIND_NODE:
            begin
                if (w.layer >= LAYERS || w.entry >= NODES || int'(w.off) + int'(w.len) > EDGES)
                    return ST_REFUSED;
                span_start[w.layer][w.entry] = w.off;
                span_size[w.layer][w.entry] = w.len;
                node_present[w.layer][w.entry] = 1'b1;
                return ST_LOADED;
            end
            KIND_EDGE:
            begin
                if (w.layer >= LAYERS || w.entry >= EDGES)
                    return ST_REFUSED;
                edge_symbol_mem[w.layer][w.entry] = w.sym;
                edge_next[w.layer][w.entry] = w.tgt;
                edge_known[w.layer][w.entry] = 1'b1;
                return ST_LOADED;
            end
            default:
                return ST_REFUSED;
        endcase
    endfunction

    function automatic diagram_word_t random_word(kind_t k);
        diagram_word_t w;
        w.kind = k;
        w.layer = LAYER_IDX_W'($urandom);
        w.entry = ENTRY_W'($urandom);
        w.off = OFFSET_W'($urandom);
        w.len = LENGTH_W'($urandom);
        w.sym = SYM_W'($urandom);
        w.tgt = TARGET_W'($urandom);
        w.pos = POS_W'({$urandom, $urandom});
        return w;
    endfunction

    function automatic int unsigned pick_node();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? NODES - 1 : 0;
        return $urandom_range(0, NODES - 1);
    endfunction

    // follows real edges so that most walks get deep, then maybe spoils one symbol
    function automatic logic [POS_W-1:0] path_position();
        logic [POS_W-1:0] pos;
        int unsigned node;
        int unsigned pick;
        int unsigned spoil;
        pos = POS_W'({$urandom, $urandom});
        node = root_copy;
        for (int d = 0; d < LAYERS; d++)
        begin
            if (node < NODES && node_present[d][node] && span_size[d][node] != 0)
            begin
                pick = span_start[d][node] + $urandom_range(0, span_size[d][node] - 1);
                pos[SYM_W*d +: SYM_W] = edge_symbol_mem[d][pick];
                node = edge_next[d][pick];
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            spoil = $urandom_range(0, LAYERS - 1);
            pos[SYM_W*spoil +: SYM_W] = SYM_W'($urandom);
        end
        return pos;
    endfunction

    task automatic send_word(input diagram_word_t w, input bit typed, input status_t want);
        status_t predicted;
        predicted = apply_word(w);
        if (burst_left == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= w.kind;
        item_ch.layer_index <= w.layer;
        item_ch.entry_index <= w.entry;
        item_ch.span_offset <= w.off;
        item_ch.span_length <= w.len;
        item_ch.edge_symbol <= w.sym;
        item_ch.edge_target <= w.tgt;
        item_ch.position    <= w.pos;
        status_due = {status_due, typed ? want : predicted};
        do
            @(posedge clk);
        while (!item_ch.ready);
        burst_left--;
        words_sent++;
    endtask

    // root is only changed with the block drained
    task automatic write_root(input logic [TARGET_W-1:0] value);
        item_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        root_copy = value;
    endtask

    // one to three nodes per layer, sorted spans whose edges mostly point into the next layer
    task automatic build_diagram();
        int unsigned layer_nodes [LAYERS][3];
        int          layer_count [LAYERS];
        int unsigned off;
        int          k;
        bit [63:0]   pool;
        diagram_word_t w;
        for (int d = 0; d < LAYERS; d++)
        begin
            layer_count[d] = $urandom_range(1, 3);
            for (int i = 0; i < 3; i++)
                layer_nodes[d][i] = pick_node();
        end
        if ($urandom_range(0, 7) != 0)
            layer_nodes[0][0] = 32'(root_copy);
        for (int d = 0; d < LAYERS; d++)
        begin
            case ($urandom_range(0, 5))
                0: build_base[d] = 0;
                1: build_base[d] = EDGES - 24;
                default: build_base[d] = $urandom_range(0, EDGES - 24);
            endcase
            for (int i = 0; i < layer_count[d]; i++)
            begin
                off = build_base[d] + 8 * i;
                k = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                pool = '0;
                while ($countones(pool) < k)
                    pool[$urandom_range(0, 63)] = 1'b1;
                k = 0;
                for (int s = 0; s < 64; s++)
                begin
                    if (pool[s])
                    begin
                        w = random_word(KIND_EDGE);
                        w.layer = LAYER_IDX_W'(d);
                        w.entry = ENTRY_W'(off + k);
                        w.sym = SYM_W'(s);
                        if (d < LAYERS - 1 && $urandom_range(0, 9) != 0)
                            w.tgt = TARGET_W'(
                                layer_nodes[d+1][$urandom_range(0, layer_count[d+1] - 1)]);
                        send_word(w, 1'b0, ST_REJECT);
                        k++;
                    end
                end
                w = random_word(KIND_NODE);
                w.layer = LAYER_IDX_W'(d);
                w.entry = ENTRY_W'(layer_nodes[d][i]);
                w.off = OFFSET_W'(off);
                w.len = LENGTH_W'(k);
                send_word(w, 1'b0, ST_REJECT);
            end
        end
    endtask

    // node loads never cover an edge that was not written
    task automatic send_noise();
        diagram_word_t w;
        int            lo_len;
        int            kmax;
        int            n;
        case ($urandom_range(0, 5))
            0: w = random_word(KIND_BAD);
            1:
            begin
                w = random_word(KIND_NODE);
                case ($urandom_range(0, 2))
                    0: w.layer = LAYER_IDX_W'($urandom_range(LAYERS, 15));
                    1:
                    begin
                        w.layer = LAYER_IDX_W'($urandom_range(0, LAYERS - 1));
                        w.entry = ENTRY_W'($urandom_range(NODES, 16383));
                    end
                    default:
                    begin
                        w.layer = LAYER_IDX_W'($urandom_range(0, LAYERS - 1));
                        w.entry = ENTRY_W'($urandom_range(0, NODES - 1));
                        lo_len = EDGES + 1 - int'(w.off);
                        w.len = LENGTH_W'($urandom_range(lo_len, 32767));
                    end
                endcase
            end
            2:
            begin
                w = random_word(KIND_NODE);
                w.layer = LAYER_IDX_W'($urandom_range(0, LAYERS - 1));
                w.entry = ENTRY_W'(pick_node());
                w.off = OFFSET_W'(build_base[w.layer] + $urandom_range(0, 20));
                kmax = $urandom_range(0, 8);
                n = 0;
                while (n < kmax && int'(w.off) + n < EDGES && edge_known[w.layer][w.off + n])
                    n++;
                w.len = LENGTH_W'(n);
            end
            3: w = random_word(KIND_EDGE);
            4: w = random_word(KIND_QUERY);
            default:
            begin
                // lands inside a recent span and can leave it unsorted
                w = random_word(KIND_EDGE);
                w.layer = LAYER_IDX_W'($urandom_range(0, LAYERS - 1));
                w.entry = ENTRY_W'(build_base[w.layer] + $urandom_range(0, 20));
            end
        endcase
        send_word(w, 1'b0, ST_REJECT);
    endtask

    always @(posedge clk)
    begin
        status_t due;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status %0d arrived with no word outstanding", result_ch.status);
                    error_count++;
                end
                else
                begin
                    due = status_due.pop_front();
                    if (result_ch.status !== due)
                    begin
                        $error("status mismatch: expected %0d, got %0d", due, result_ch.status);
                        error_count++;
                    end
                end
            end
            if (ready_hold == 0)
            begin
                if (!result_ch.ready)
                begin
                    result_ch.ready <= 1'b1;
                    ready_hold = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                end
                else
                begin
                    result_ch.ready <= 1'b0;
                    ready_hold = $urandom_range(1, 8);
                end
            end
            else
            begin
                ready_hold--;
            end
        end
    end

    initial
    begin
        int phase;
        logic [TARGET_W-1:0] root_pick;
        words_sent = 0;
        burst_left = 0;
        root_copy = '0;
        for (int d = 0; d < LAYERS; d++)
            build_base[d] = 0;
        item_ch.valid       = 1'b0;
        item_ch.kind        = KIND_QUERY;
        item_ch.layer_index = '0;
        item_ch.entry_index = '0;
        item_ch.span_offset = '0;
        item_ch.span_length = '0;
        item_ch.edge_symbol = '0;
        item_ch.edge_target = '0;
        item_ch.position    = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            send_word(DIRECTED_ROWS[i].w, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        phase = 0;
        while (words_sent < 1480)
        begin
            case (phase)
                0: root_pick = '0;
                1: root_pick = TARGET_W'(NODES - 1);
                default: root_pick = TARGET_W'(pick_node());
            endcase
            write_root(root_pick);
            build_diagram();
            repeat (60)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    send_word('{KIND_QUERY, 4'($urandom), 14'($urandom), 14'($urandom),
                                15'($urandom), 6'($urandom), 12'($urandom), path_position()},
                              1'b0, ST_REJECT);
                end
                else
                begin
                    send_noise();
                end
            end
            phase++;
        end
        item_ch.valid <= 1'b0;

        while (status_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("layered_decision_diagram_lookup_test: clean");
        else
            $display("layered_decision_diagram_lookup_test: errors");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("layered_decision_diagram_lookup_test: errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ldd_pkg.sv
sv/ldd_if.sv
sv/ldd_dpath.sv
sv/ldd_ctrl.sv
sv/layered_decision_diagram_lookup.sv
tb/layered_decision_diagram_lookup_test.sv
